// ===== hw/rtl/uvsg_pkg.sv =====
// shared constants for the uv sphere vertex generator
// used by the top level and the sin/cos pipeline, no dependencies
package uvsg_pkg;

  // configuration register indexes
  localparam int          CFG_IDX_W        = 2;
  localparam logic [1:0]  CFG_SECTOR_COUNT = 2'd0;
  localparam logic [1:0]  CFG_STACK_COUNT  = 2'd1;

  // phase in units of 2^-32 turn, trig values in signed q2.30
  localparam int PHASE_W = 32;
  localparam int TRIG_W  = 32;

  // latency of the sin/cos pipeline: fold, angle, square, five taylor steps, quadrant
  localparam int SC_LAT = 14;

  // pi in q2.30 for the phase to radian multiply
  localparam logic [31:0] PI_Q30 = 32'hC90FDAA2;

endpackage

// ===== hw/rtl/uv_sphere_vertex_generator_core.sv =====
// uv sphere vertex generator, top level
// depends on uvsg_pkg and uvsg_sincos
//
// usage
//   config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
//   (0 sector count, 1 stack count; other indexes ignored). write only
//   while no request is in flight. a count of 0 acts as 1, a count above
//   MAX_DIVISIONS acts as MAX_DIVISIONS. both counts reset to 64
//   input stream: one grid point per request (sector and stack index),
//   indexes above the counts are clamped
//   output stream: one vertex per request (position = normal in signed
//   q(16-POS_FRAC_BITS).POS_FRAC_BITS, texture coords in unsigned q1.16), in request order
// timing
//   m_axis_tvalid rises once an accepted input request has passed through
//   one clamp stage, an 11-stage radix-2 divider (3 quotient bits a stage),
//   a phase stage, the 14-stage sin/cos pipeline, a product stage and a
//   rounding stage, then the output register
//   one request per cycle sustained while the receiver keeps up, every stage is fully pipelined
// reset and stall
//   reset empties the pipeline and output buffers, payload is not cleared
//   a stalled receiver fills the output register, then a skid register;
//   the whole pipeline then holds and s_axis_tready drops (registered)
module uv_sphere_vertex_generator_core #(
  parameter int MAX_DIVISIONS = 1024,
  parameter int POS_FRAC_BITS = 14
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [uvsg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [10:0]                    cfg_wdata_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // sector_index [10:0], stack_index [21:11], zero pad
  input  logic [23:0]                    s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // pos_x [15:0], pos_y [31:16], pos_z [47:32], tex_u [64:48], tex_v [81:65], zero pad
  output logic [87:0]                    m_axis_tdata
);

  localparam int DIV_STEP   = 3;
  localparam int DIV_STAGES = 11;
  localparam int QUO_W      = 1 + DIV_STEP * DIV_STAGES;
  localparam int V_T0       = DIV_STAGES + 1;
  localparam int V_SC       = V_T0 + uvsg_pkg::SC_LAT;
  localparam int V_RND      = V_SC + 2;
  localparam int TEX_DLY    = V_RND - V_T0;
  localparam int SH_Y       = 30 - POS_FRAC_BITS;
  localparam int SH_XZ      = 60 - POS_FRAC_BITS;

  // effective count: zero acts as one, clamp to the maximum
  function automatic logic [10:0] eff_count(logic [10:0] v);
    if (v == 11'd0) return 11'd1;
    if ({21'b0, v} > 32'(MAX_DIVISIONS)) return 11'(MAX_DIVISIONS);
    return v;
  endfunction

  // shift right with rounding half away from zero, low 16 bits
  function automatic logic [15:0] round_out(logic signed [63:0] v, int sh);
    logic        neg;
    logic [63:0] mag;
    neg = v[63];
    mag = neg ? 64'(-v) : 64'(v);
    if (sh > 0) mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (neg) mag = -mag;
    return mag[15:0];
  endfunction

  // ---------------- configuration ----------------
  logic [10:0] cnt_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q[0] <= 11'd64;
      cnt_q[1] <= 11'd64;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        uvsg_pkg::CFG_SECTOR_COUNT: cnt_q[0] <= eff_count(cfg_wdata_i);
        uvsg_pkg::CFG_STACK_COUNT:  cnt_q[1] <= eff_count(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic        adv;
  logic        v_q [V_RND+1];
  logic        out_v_q, skid_v_q;
  logic [87:0] out_q, skid_q, res_d;

  // the pipeline moves whenever the skid register is free
  assign adv           = !skid_v_q;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= V_RND; i++) v_q[i] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= s_axis_tvalid;
      for (int i = 1; i <= V_RND; i++) v_q[i] <= v_q[i-1];
    end
  end

  // ---------------- clamp and divider ----------------
  // quotient = floor(index * 2^33 / count), index <= count
  logic [10:0]      div_rem_q [DIV_STAGES+1][2];
  logic [QUO_W-1:0] div_quo_q [DIV_STAGES+1][2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_axis
    logic [10:0] idx, clamped;
    assign idx     = s_axis_tdata[ax*11 +: 11];
    assign clamped = (idx > cnt_q[ax]) ? cnt_q[ax] : idx;

    always_ff @(posedge clk_i) begin
      if (adv) begin
        // integer bit is set only when the index equals the count (a full turn in azimuth), then the remainder is zero
        div_quo_q[0][ax] <= {{(QUO_W-1){1'b0}}, clamped == cnt_q[ax]};
        div_rem_q[0][ax] <= (clamped == cnt_q[ax]) ? 11'd0 : clamped;
      end
    end

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      logic [10:0]      rem_d;
      logic [QUO_W-1:0] quo_d;

      always_comb begin
        logic [11:0] r2;
        rem_d = div_rem_q[k][ax];
        quo_d = div_quo_q[k][ax];
        for (int b = 0; b < DIV_STEP; b++) begin
          r2 = {rem_d, 1'b0};
          if (r2 >= {1'b0, cnt_q[ax]}) begin
            quo_d = {quo_d[QUO_W-2:0], 1'b1};
            rem_d = 11'(r2 - {1'b0, cnt_q[ax]});
          end else begin
            quo_d = {quo_d[QUO_W-2:0], 1'b0};
            rem_d = r2[10:0];
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv) begin
          div_rem_q[k+1][ax] <= rem_d;
          div_quo_q[k+1][ax] <= quo_d;
        end
      end
    end
  end

  // ---------------- phase and texture coordinates ----------------
  logic [uvsg_pkg::PHASE_W-1:0] phase_q [2];
  logic [16:0]                  tex_q   [2];
  logic [16:0]                  tex_dly_q [TEX_DLY][2];
  logic [QUO_W-1:0]             qa, qp;
  logic [QUO_W:0]               az_sum;
  logic [QUO_W-1:0]             pol_sum;
  logic [18:0]                  tu_sum, tv_sum;

  assign qa      = div_quo_q[DIV_STAGES][0];
  assign qp      = div_quo_q[DIV_STAGES][1];
  // azimuth rounds q/2, polar angle rounds q/4 (half turns), texture rounds q/2^17
  assign az_sum  = {1'b0, qa} + {{QUO_W{1'b0}}, 1'b1};
  assign pol_sum = {1'b0, qp[QUO_W-1:1]} + {{(QUO_W-1){1'b0}}, 1'b1};
  assign tu_sum  = {1'b0, qa[QUO_W-1:16]} + 19'd1;
  assign tv_sum  = {1'b0, qp[QUO_W-1:16]} + 19'd1;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      phase_q[0] <= az_sum[32:1];
      phase_q[1] <= pol_sum[32:1];
      tex_q[0]   <= tu_sum[17:1];
      tex_q[1]   <= tv_sum[17:1];
      tex_dly_q[0] <= tex_q;
      for (int i = 1; i < TEX_DLY; i++) tex_dly_q[i] <= tex_dly_q[i-1];
    end
  end

  // ---------------- sin and cos ----------------
  logic signed [uvsg_pkg::TRIG_W-1:0] sin_w [2];
  logic signed [uvsg_pkg::TRIG_W-1:0] cos_w [2];

  for (genvar ax = 0; ax < 2; ax++) begin : g_trig
    uvsg_sincos u_sincos (
      .clk_i   (clk_i),
      .en_i    (adv),
      .phase_i (phase_q[ax]),
      .sin_o   (sin_w[ax]),
      .cos_o   (cos_w[ax])
    );
  end

  // ---------------- products and rounding ----------------
  logic signed [63:0] px_q, pz_q;
  logic signed [31:0] py_q;
  logic [15:0]        pos_x_q, pos_y_q, pos_z_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      px_q    <= cos_w[0] * sin_w[1];
      pz_q    <= sin_w[0] * sin_w[1];
      py_q    <= cos_w[1];
      pos_x_q <= round_out(px_q, SH_XZ);
      pos_y_q <= round_out({{32{py_q[31]}}, py_q}, SH_Y);
      pos_z_q <= round_out(pz_q, SH_XZ);
    end
  end

  assign res_d = {6'b0, tex_dly_q[TEX_DLY-1][1], tex_dly_q[TEX_DLY-1][0],
                  pos_z_q, pos_y_q, pos_x_q};

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (m_axis_tready || !out_v_q) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= v_q[V_RND];
      end
    end else if (v_q[V_RND]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (m_axis_tready || !out_v_q) begin
      out_q <= skid_v_q ? skid_q : res_d;
    end else if (adv && v_q[V_RND]) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule

// ===== hw/rtl/uvsg_sincos.sv =====
// pipelined sin and cos of a phase given in units of 2^-32 turn
// folds to [0, pi/4], runs taylor series in q2.30; depends on uvsg_pkg
module uvsg_sincos (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [uvsg_pkg::PHASE_W-1:0]        phase_i,
  output logic signed [uvsg_pkg::TRIG_W-1:0]  sin_o,
  output logic signed [uvsg_pkg::TRIG_W-1:0]  cos_o
);

  // exact floor division by small constants: (x * m) >> sh for x < 2^30
  localparam logic [30:0] SIN_RECIP [4] = '{31'd1431655766, 31'd1717986919,
                                            31'd1636178018, 31'd1908874354};
  localparam int          SIN_SHIFT [4] = '{33, 35, 36, 37};
  localparam logic [30:0] COS_RECIP [5] = '{31'd1073741824, 31'd1431655766,
                                            31'd1145324613, 31'd1227133514,
                                            31'd1527099484};
  localparam int          COS_SHIFT [5] = '{31, 34, 35, 36, 37};

  // fold stage
  logic [29:0] f1_q;
  logic [1:0]  qd1_q;
  logic        sel1_q;
  // angle stage
  logic [30:0] a_q;
  logic [1:0]  qd2_q;
  logic        sel2_q;

  // taylor state after j steps
  logic [30:0]        st_ts  [5];
  logic [30:0]        st_tc  [5];
  logic signed [31:0] st_ss  [6];
  logic signed [31:0] st_sc  [6];
  logic [29:0]        st_a2  [5];
  logic [1:0]         st_qd  [6];
  logic               st_sel [6];
  // term times a2, between the two halves of a step
  logic [30:0]        mid_ps  [4];
  logic [30:0]        mid_pc  [5];
  logic signed [31:0] mid_ss  [5];
  logic signed [31:0] mid_sc  [5];
  logic [29:0]        mid_a2  [4];
  logic [1:0]         mid_qd  [5];
  logic               mid_sel [5];

  logic [29:0] g_d;
  logic [29:0] f1_d;
  logic [61:0] a_prod;
  logic [61:0] a2_prod;

  assign g_d    = phase_i[29:0];
  assign f1_d   = (g_d <= 30'h20000000) ? g_d : 30'(31'h40000000 - {1'b0, g_d});
  assign a_prod = {32'b0, f1_q} * {30'b0, uvsg_pkg::PI_Q30};
  assign a2_prod = {31'b0, a_q} * {31'b0, a_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q      <= f1_d;
      qd1_q     <= phase_i[31:30];
      sel1_q    <= (g_d <= 30'h20000000);
      a_q       <= a_prod[61:31];
      qd2_q     <= qd1_q;
      sel2_q    <= sel1_q;
      st_ts[0]  <= a_q;
      st_tc[0]  <= 31'h40000000;
      st_ss[0]  <= $signed({1'b0, a_q});
      st_sc[0]  <= 32'sh40000000;
      st_a2[0]  <= a2_prod[59:30];
      st_qd[0]  <= qd2_q;
      st_sel[0] <= sel2_q;
    end
  end

  for (genvar j = 0; j < 5; j++) begin : g_step
    logic [60:0] pc_prod;
    logic [61:0] tc_prod;
    logic [30:0] tc_d;

    assign pc_prod = {30'b0, st_tc[j]} * {31'b0, st_a2[j]};
    assign tc_prod = {31'b0, mid_pc[j]} * {31'b0, COS_RECIP[j]};
    assign tc_d    = 31'(tc_prod >> COS_SHIFT[j]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        mid_pc[j]  <= pc_prod[60:30];
        mid_ss[j]  <= st_ss[j];
        mid_sc[j]  <= st_sc[j];
        mid_qd[j]  <= st_qd[j];
        mid_sel[j] <= st_sel[j];
        st_sc[j+1] <= (j % 2 == 0) ? mid_sc[j] - $signed({1'b0, tc_d})
                                   : mid_sc[j] + $signed({1'b0, tc_d});
        st_qd[j+1]  <= mid_qd[j];
        st_sel[j+1] <= mid_sel[j];
      end
    end

    if (j < 4) begin : g_sin
      logic [60:0] ps_prod;
      logic [61:0] ts_prod;
      logic [30:0] ts_d;

      assign ps_prod = {30'b0, st_ts[j]} * {31'b0, st_a2[j]};
      assign ts_prod = {31'b0, mid_ps[j]} * {31'b0, SIN_RECIP[j]};
      assign ts_d    = 31'(ts_prod >> SIN_SHIFT[j]);

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          mid_ps[j]  <= ps_prod[60:30];
          mid_a2[j]  <= st_a2[j];
          st_ts[j+1] <= ts_d;
          st_tc[j+1] <= tc_d;
          st_a2[j+1] <= mid_a2[j];
          st_ss[j+1] <= (j % 2 == 0) ? mid_ss[j] - $signed({1'b0, ts_d})
                                     : mid_ss[j] + $signed({1'b0, ts_d});
        end
      end
    end else begin : g_sin_done
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          st_ss[j+1] <= mid_ss[j];
        end
      end
    end
  end

  // quadrant symmetry
  logic signed [31:0] sq, cq, sin_d, cos_d;
  assign sq = st_sel[5] ? st_ss[5] : st_sc[5];
  assign cq = st_sel[5] ? st_sc[5] : st_ss[5];

  always_comb begin
    case (st_qd[5])
      2'd0:    begin sin_d = sq;  cos_d = cq;  end
      2'd1:    begin sin_d = cq;  cos_d = -sq; end
      2'd2:    begin sin_d = -sq; cos_d = -cq; end
      default: begin sin_d = -cq; cos_d = sq;  end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= sin_d;
      cos_o <= cos_d;
    end
  end

endmodule

// ===== hw/rtl/uvsg_checker.sv =====
// port-level checks for the uv sphere vertex generator
// bound to uv_sphere_vertex_generator_core, no package dependency
module uvsg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output request dropped or changed while stalled");

  // input backpressure only when a result is waiting
  a_bp_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result waiting");

  // backpressure clears in the cycle after the receiver takes a result
  a_bp_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready && m_axis_tready |=> s_axis_tready)
    else $error("input stall not released");

  // texture coordinates never exceed one
  a_tex_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[64:48] <= 17'd65536) &&
                      (m_axis_tdata[81:65] <= 17'd65536))
    else $error("texture coordinate out of range");

endmodule

bind uv_sphere_vertex_generator_core uvsg_checker u_uvsg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/tb_uv_sphere_vertex_generator_core.sv =====
// testbench for the uv sphere vertex generator core: random and directed grid points
// checked against a fixed-point sin/cos predictor kept in this file; depends on uvsg_pkg
`timescale 1ns / 100ps

module tb_uv_sphere_vertex_generator_core;

  localparam int MAX_DIV  = 1024;
  localparam int FRAC     = 14;
  localparam int LATENCY  = 30;
  localparam int WD_LIMIT = 5000;

  typedef struct packed {
    logic [10:0] stack_idx;
    logic [10:0] sector_idx;
  } point_t;

  typedef struct packed {
    logic [16:0] tex_v;
    logic [16:0] tex_u;
    logic [15:0] pos_z;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
  } vertex_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [uvsg_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [10:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;

  uv_sphere_vertex_generator_core dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor copy of the count registers
  logic [10:0] sector_cnt_q = 11'd64;
  logic [10:0] stack_cnt_q  = 11'd64;

  point_t  pending_points[$];
  vertex_t expected_vertices[$];
  int      n_errors = 0;
  int      n_checked = 0;
  int      idle_cycles = 0;
  bit      src_gaps = 1'b1;
  bit      sink_gaps = 1'b1;
  bit      sink_hold = 1'b0;
  bit      src_pause = 1'b0;

  function automatic longint unsigned eff_count(logic [10:0] r);
    if (r == 11'd0) return 64'd1;
    if (r > MAX_DIV) return 64'(MAX_DIV);
    return 64'(r);
  endfunction

  // taylor series of an angle in [0, pi/4], q2.30
  function automatic void taylor(input longint a, output longint sv, output longint cv);
    longint a2, term, sum;
    a2 = (a * a) >>> 30;
    term = a; sum = a;
    for (int k = 1; k <= 4; k++) begin
      term = ((term * a2) >>> 30) / (longint'(2 * k) * (2 * k + 1));
      sum += (k & 1) ? -term : term;
    end
    sv = sum;
    term = 64'sd1 << 30; sum = term;
    for (int k = 1; k <= 5; k++) begin
      term = ((term * a2) >>> 30) / (longint'(2 * k - 1) * (2 * k));
      sum += (k & 1) ? -term : term;
    end
    cv = sum;
  endfunction

  // fold a phase in 2^-32 turns into the first octant, then restore quadrant
  function automatic void phase_sincos(input logic [31:0] r, output longint sv,
                                       output longint cv);
    longint unsigned g, ang;
    longint s0, c0, sq, cq;
    g = 64'(r[29:0]);
    if (g <= 64'h2000_0000) begin
      ang = (g * 64'(uvsg_pkg::PI_Q30)) >> 31;
      taylor(longint'(ang), s0, c0);
      sq = s0; cq = c0;
    end else begin
      ang = ((64'h4000_0000 - g) * 64'(uvsg_pkg::PI_Q30)) >> 31;
      taylor(longint'(ang), s0, c0);
      sq = c0; cq = s0;
    end
    case (r[31:30])
      2'd0: begin sv = sq;  cv = cq;  end
      2'd1: begin sv = cq;  cv = -sq; end
      2'd2: begin sv = -sq; cv = -cq; end
      default: begin sv = -cq; cv = sq; end
    endcase
  endfunction

  // round half away from zero on the magnitude
  function automatic logic [15:0] round_mag(longint v, int sh);
    longint unsigned mag;
    mag = (v < 0) ? longint'(-v) : v;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    if (v < 0) mag = -mag;
    return mag[15:0];
  endfunction

  function automatic vertex_t vertex_of(point_t p);
    longint unsigned n, m, s, t;
    logic [31:0] az, pol;
    longint sa, ca, sp, cp;
    vertex_t v;
    n = eff_count(sector_cnt_q);
    m = eff_count(stack_cnt_q);
    s = 64'(p.sector_idx); t = 64'(p.stack_idx);
    if (s > n) s = n;
    if (t > m) t = m;
    az  = 32'(((s << 33) + n) / (2 * n));
    pol = 32'(((t << 32) + m) / (2 * m));
    phase_sincos(az, sa, ca);
    phase_sincos(pol, sp, cp);
    v.pos_x = round_mag(ca * sp, 60 - FRAC);
    v.pos_y = round_mag(cp, 30 - FRAC);
    v.pos_z = round_mag(sa * sp, 60 - FRAC);
    v.tex_u = 17'(((s << 17) + n) / (2 * n));
    v.tex_v = 17'(((t << 17) + m) / (2 * m));
    return v;
  endfunction

  // driver: one grid point per request, random bursts of gaps
  int src_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_vertices.insert(expected_vertices.size(),
                                 vertex_of(point_t'(s_axis_tdata[21:0])));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (src_gaps && $urandom_range(0, 9) == 0) begin
          src_gap <= int'($urandom_range(1, 17)) - 1;
          s_axis_tvalid <= 1'b0;
        end else if (pending_points.size() > 0 && !src_pause) begin
          s_axis_tdata <= {2'b00, pending_points.pop_front()};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each vertex with the oldest prediction
  int sink_gap = 0;
  always @(posedge clk_i) begin
    vertex_t got, exp_v;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = vertex_t'(m_axis_tdata[81:0]);
        if (expected_vertices.size() == 0) begin
          $error("vertex with no request pending");
          n_errors++;
        end else begin
          exp_v = expected_vertices.pop_front();
          n_checked++;
          if (got.pos_x !== exp_v.pos_x) begin
            $error("pos_x expected %0d got %0d", $signed(exp_v.pos_x), $signed(got.pos_x));
            n_errors++;
          end
          if (got.pos_y !== exp_v.pos_y) begin
            $error("pos_y expected %0d got %0d", $signed(exp_v.pos_y), $signed(got.pos_y));
            n_errors++;
          end
          if (got.pos_z !== exp_v.pos_z) begin
            $error("pos_z expected %0d got %0d", $signed(exp_v.pos_z), $signed(got.pos_z));
            n_errors++;
          end
          if (got.tex_u !== exp_v.tex_u) begin
            $error("tex_u expected %0d got %0d", exp_v.tex_u, got.tex_u);
            n_errors++;
          end
          if (got.tex_v !== exp_v.tex_v) begin
            $error("tex_v expected %0d got %0d", exp_v.tex_v, got.tex_v);
            n_errors++;
          end
        end
      end
      if (sink_hold) begin
        m_axis_tready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap <= sink_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 9) == 0) begin
        sink_gap <= int'($urandom_range(1, 17)) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no transfer on either stream
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
          $display("CHECKS FAILED");
          $finish;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_points.size() > 0 || expected_vertices.size() > 0 || s_axis_tvalid)
      @(negedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
  endtask

  // register write while the pipeline is empty; predictor copy follows
  task automatic write_count(input logic [uvsg_pkg::CFG_IDX_W-1:0] idx,
                             input logic [10:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == uvsg_pkg::CFG_SECTOR_COUNT) sector_cnt_q = val;
    else if (idx == uvsg_pkg::CFG_STACK_COUNT) stack_cnt_q = val;
    @(posedge clk_i);
  endtask

  task automatic push_point(input logic [10:0] s, input logic [10:0] t);
    point_t p;
    p.sector_idx = s;
    p.stack_idx = t;
    pending_points.insert(pending_points.size(), p);
  endtask

  // mostly in-range indexes, sometimes any 11-bit value
  task automatic push_random(input int cnt);
    longint unsigned n, m;
    n = eff_count(sector_cnt_q);
    m = eff_count(stack_cnt_q);
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 7) == 0)
        push_point(11'($urandom_range(0, 2047)), 11'($urandom_range(0, 2047)));
      else
        push_point(11'($urandom_range(0, 32'(n))), 11'($urandom_range(0, 32'(m))));
    end
  endtask

  initial begin
    logic [10:0] sc_vals[6];
    logic [10:0] st_vals[6];
    sc_vals = '{11'd1, 11'd1024, 11'd0, 11'd2047, 11'd7, 11'd600};
    st_vals = '{11'd1024, 11'd1, 11'd2047, 11'd0, 11'd13, 11'd333};

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset counts, poles, full turn, clamping, index extremes
    push_point(11'd0, 11'd0);
    push_point(11'd64, 11'd64);
    push_point(11'd16, 11'd32);
    push_point(11'd32, 11'd16);
    push_point(11'd48, 11'd1);
    push_point(11'd65, 11'd65);
    push_point(11'h7FF, 11'h7FF);
    push_point(11'h555, 11'h2AA);
    push_point(11'h2AA, 11'h555);
    push_point(11'd1, 11'd63);
    push_point(11'd63, 11'd0);
    wait_drained();

    // unknown register index is ignored
    write_count(2'd2, 11'd5);
    write_count(2'd3, 11'd9);
    push_point(11'd64, 11'd32);
    push_point(11'd1024, 11'd1024);
    wait_drained();

    // long receiver hold so the pipeline backs up and stalls the input
    sink_hold = 1'b1;
    push_random(120);
    repeat (300) @(posedge clk_i);
    sink_hold = 1'b0;
    wait_drained();

    // sweep settings, extremes included, random points in each
    foreach (sc_vals[i]) begin
      write_count(uvsg_pkg::CFG_SECTOR_COUNT, sc_vals[i]);
      write_count(uvsg_pkg::CFG_STACK_COUNT, st_vals[i]);
      push_point(11'd0, 11'd0);
      push_point(11'h7FF, 11'h7FF);
      push_random(120);
      // sender pauses mid-stream until every vertex is back
      while (pending_points.size() > 60) @(negedge clk_i);
      src_pause = 1'b1;
      while (expected_vertices.size() > 0 || s_axis_tvalid) @(negedge clk_i);
      src_pause = 1'b0;
      wait_drained();
    end

    // last part without gaps on either side
    write_count(uvsg_pkg::CFG_SECTOR_COUNT, 11'd64);
    write_count(uvsg_pkg::CFG_STACK_COUNT, 11'd32);
    src_gaps = 1'b0;
    sink_gaps = 1'b0;
    push_random(230);
    wait_drained();

    $display("covered %0d vertices over count settings 0..2047 incl. clamping and stalls",
             n_checked);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
